/* sv/scl_pkg.sv */
// scl_pkg: beat types, status and phase codes for the slope corridor line simplifier
// no dependencies; used by every file of the block
`timescale 1ns / 1ps

package scl_pkg;

	typedef struct packed {
		logic [15:0]        sample_tick;
		logic signed [15:0] sample_value;
		logic               last_sample;
	} in_t;

	typedef struct packed {
		logic [15:0]        point_tick;
		logic signed [15:0] point_value;
		logic [1:0]         status;
		logic               last_result;
	} out_t;

	// up to two results from one sample
	typedef struct packed {
		logic [1:0] n;
		out_t       r0;
		out_t       r1;
	} emit_t;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_CAP   = 2'd1;
	localparam logic [1:0] ST_ORDER = 2'd2;
	localparam logic [1:0] ST_SHORT = 2'd3;

	localparam logic [1:0] PH_IDLE     = 2'd0;
	localparam logic [1:0] PH_ANCHOR   = 2'd1;
	localparam logic [1:0] PH_CORRIDOR = 2'd2;
	localparam logic [1:0] PH_DROP     = 2'd3;

	localparam logic REG_CAPACITY  = 1'b0;
	localparam logic REG_TOLERANCE = 1'b1;

	localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
	localparam logic [9:0]  SIMPL_ERR_Q15  = 10'd1;

	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);

	function automatic out_t err_point(logic [1:0] st);
		out_t r;
		r             = '0;
		r.status      = st;
		r.last_result = 1'b1;
		return r;
	endfunction

	function automatic out_t ok_point(logic [15:0] t, logic signed [15:0] v, logic last);
		out_t r;
		r.point_tick  = t;
		r.point_value = v;
		r.status      = ST_OK;
		r.last_result = last;
		return r;
	endfunction

endpackage

/* sv/scl_core.sv */
// scl_core: corridor test, anchor and slope state, breakpoint and error results
// depends on scl_pkg; one sample per cycle when go is high
`timescale 1ns / 1ps

module scl_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  scl_pkg::in_t        item,
	input  logic [15:0]         capacity,
	input  logic [9:0]          tolerance,
	output scl_pkg::emit_t      emit
);

	logic [1:0]         phase_q, phase_d;
	logic [15:0]        anc_tick_q, anc_tick_d;
	logic signed [15:0] anc_val_q, anc_val_d;
	logic [15:0]        prev_tick_q, prev_tick_d;
	logic signed [15:0] prev_val_q, prev_val_d;
	logic signed [17:0] lnum_q, lnum_d, unum_q, unum_d;
	logic [15:0]        lden_q, lden_d, uden_q, uden_d;
	logic [15:0]        cnt_q, cnt_d;

	logic signed [16:0] d_a, d_p;
	logic [15:0]        s_a, s_p;
	logic signed [16:0] s_a_s, lden_s, uden_s;
	logic signed [17:0] tol_s, dl_a, du_a, dl_p, du_p;
	logic signed [33:0] p_dl, p_du;
	logic signed [34:0] p_ls, p_us, p_tl, p_tu;
	logic               above_low, below_up, tight_low, tight_up;
	logic               brk;
	logic [15:0]        cnt1;
	logic [1:0]         end_phase;

	// deltas from the anchor and from the previous sample
	assign d_a    = {item.sample_value[15], item.sample_value} - {anc_val_q[15], anc_val_q};
	assign d_p    = {item.sample_value[15], item.sample_value} - {prev_val_q[15], prev_val_q};
	assign s_a    = item.sample_tick - anc_tick_q;
	assign s_p    = item.sample_tick - prev_tick_q;
	assign s_a_s  = {1'b0, s_a};
	assign lden_s = {1'b0, lden_q};
	assign uden_s = {1'b0, uden_q};
	assign tol_s  = {8'b0, tolerance};
	assign dl_a   = {d_a[16], d_a} - tol_s;
	assign du_a   = {d_a[16], d_a} + tol_s;
	assign dl_p   = {d_p[16], d_p} - tol_s;
	assign du_p   = {d_p[16], d_p} + tol_s;

	// independent cross-products
	assign p_dl = d_a * lden_s;
	assign p_du = d_a * uden_s;
	assign p_ls = lnum_q * s_a_s;
	assign p_us = unum_q * s_a_s;
	assign p_tl = dl_a * lden_s;
	assign p_tu = du_a * uden_s;

	assign above_low = p_dl >= p_ls;
	assign below_up  = p_du <= p_us;
	assign tight_low = p_tl > p_ls;
	assign tight_up  = p_tu < p_us;

	always_comb begin
		phase_d     = phase_q;
		anc_tick_d  = anc_tick_q;
		anc_val_d   = anc_val_q;
		prev_tick_d = prev_tick_q;
		prev_val_d  = prev_val_q;
		lnum_d      = lnum_q;
		lden_d      = lden_q;
		unum_d      = unum_q;
		uden_d      = uden_q;
		cnt_d       = cnt_q;
		emit        = '0;
		brk         = (phase_q == scl_pkg::PH_CORRIDOR) && !(above_low && below_up);
		cnt1        = brk ? cnt_q + 16'd1 : cnt_q;
		end_phase   = item.last_sample ? scl_pkg::PH_IDLE : scl_pkg::PH_DROP;

		case (phase_q)
			scl_pkg::PH_DROP: begin
				if (item.last_sample) begin
					phase_d = scl_pkg::PH_IDLE;
				end
			end
			scl_pkg::PH_IDLE: begin
				emit.n = 2'd1;
				if (item.last_sample) begin
					emit.r0 = scl_pkg::err_point(scl_pkg::ST_SHORT);
				end else if (capacity == 16'd0) begin
					emit.r0 = scl_pkg::err_point(scl_pkg::ST_CAP);
					phase_d = scl_pkg::PH_DROP;
				end else begin
					emit.r0     = scl_pkg::ok_point(item.sample_tick, item.sample_value, 1'b0);
					cnt_d       = 16'd1;
					anc_tick_d  = item.sample_tick;
					anc_val_d   = item.sample_value;
					prev_tick_d = item.sample_tick;
					prev_val_d  = item.sample_value;
					phase_d     = scl_pkg::PH_ANCHOR;
				end
			end
			default: begin
				if (item.sample_tick <= prev_tick_q) begin
					emit.n  = 2'd1;
					emit.r0 = scl_pkg::err_point(scl_pkg::ST_ORDER);
					phase_d = end_phase;
				end else if (brk && (cnt_q >= capacity)) begin
					emit.n  = 2'd1;
					emit.r0 = scl_pkg::err_point(scl_pkg::ST_CAP);
					phase_d = end_phase;
				end else begin
					if (phase_q == scl_pkg::PH_ANCHOR || brk) begin
						// new corridor from the previous sample
						lnum_d = dl_p;
						lden_d = s_p;
						unum_d = du_p;
						uden_d = s_p;
					end else begin
						if (tight_low) begin
							lnum_d = dl_a;
							lden_d = s_a;
						end
						if (tight_up) begin
							unum_d = du_a;
							uden_d = s_a;
						end
					end
					if (brk) begin
						emit.n     = 2'd1;
						emit.r0    = scl_pkg::ok_point(prev_tick_q, prev_val_q, 1'b0);
						anc_tick_d = prev_tick_q;
						anc_val_d  = prev_val_q;
					end
					cnt_d       = cnt1;
					prev_tick_d = item.sample_tick;
					prev_val_d  = item.sample_value;
					phase_d     = scl_pkg::PH_CORRIDOR;
					if (item.last_sample) begin
						phase_d = scl_pkg::PH_IDLE;
						if (cnt1 >= capacity) begin
							if (brk) begin
								emit.r1 = scl_pkg::err_point(scl_pkg::ST_CAP);
							end else begin
								emit.r0 = scl_pkg::err_point(scl_pkg::ST_CAP);
							end
						end else begin
							cnt_d = cnt1 + 16'd1;
							if (brk) begin
								emit.r1 = scl_pkg::ok_point(item.sample_tick,
									item.sample_value, 1'b1);
							end else begin
								emit.r0 = scl_pkg::ok_point(item.sample_tick,
									item.sample_value, 1'b1);
							end
						end
						emit.n = brk ? 2'd2 : 2'd1;
					end
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= scl_pkg::PH_IDLE;
			anc_tick_q  <= '0;
			anc_val_q   <= '0;
			prev_tick_q <= '0;
			prev_val_q  <= '0;
			lnum_q      <= '0;
			lden_q      <= 16'd1;
			unum_q      <= '0;
			uden_q      <= 16'd1;
			cnt_q       <= '0;
		end else if (go) begin
			phase_q     <= phase_d;
			anc_tick_q  <= anc_tick_d;
			anc_val_q   <= anc_val_d;
			prev_tick_q <= prev_tick_d;
			prev_val_q  <= prev_val_d;
			lnum_q      <= lnum_d;
			lden_q      <= lden_d;
			unum_q      <= unum_d;
			uden_q      <= uden_d;
			cnt_q       <= cnt_d;
		end
	end

endmodule

/* sv/scl_queue.sv */
// scl_queue: result queue, takes up to two results a cycle and hands out one beat
// depends on scl_pkg
`timescale 1ns / 1ps

module scl_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           go,
	input  scl_pkg::emit_t emit,
	output logic           room,
	output logic           point_valid,
	input  logic           point_stall,
	output scl_pkg::out_t  point
);

	scl_pkg::out_t             mem_q [scl_pkg::Q_DEPTH];
	logic [scl_pkg::Q_AW-1:0]  wr_q, rd_q;
	logic [scl_pkg::Q_AW:0]    cnt_q;
	logic [1:0]                push_n;
	logic                      pop;

	assign push_n      = go ? emit.n : 2'd0;
	assign point_valid = (cnt_q != '0);
	assign pop         = point_valid && !point_stall;
	assign point       = mem_q[rd_q];
	assign room        = cnt_q <= (scl_pkg::Q_AW+1)'(scl_pkg::Q_DEPTH - 2);

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			mem_q[wr_q] <= emit.r0;
		end
		if (push_n == 2'd2) begin
			mem_q[wr_q + scl_pkg::Q_AW'(1)] <= emit.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + scl_pkg::Q_AW'(push_n);
			rd_q  <= rd_q + scl_pkg::Q_AW'(pop);
			cnt_q <= cnt_q + (scl_pkg::Q_AW+1)'(push_n) - (scl_pkg::Q_AW+1)'(pop);
		end
	end

endmodule

/* sv/slope_corridor_line_simplifier_top.sv */
// slope_corridor_line_simplifier_top: input register, corridor core, result queue
// depends on scl_pkg, scl_core, scl_queue
// Use: samples (tick, value, last flag) enter on the sample channel, one beat
// per sample, handshake sample_valid / sample_stall. Breakpoints and error
// results leave on the point channel, handshake point_valid / point_stall.
// The first result of a sample passes the input register and then the result
// queue before it shows on the point port. One sample is taken per cycle while
// results drain as fast as they are made; a sample that yields two results (a
// breakpoint plus the final point) puts an extra beat on the point side, and
// the four-entry result queue then fills and raises sample_stall until it has
// room for two.
// The corridor test is combinational: six independent cross-products of
// up to 18 x 17 bits and their compares set the clock.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 capacity,
// 1 tolerance); write only while the block is idle.
// Reset: clears the queue, the input register and the stream state, and sets
// capacity to 65535 and tolerance to 1. While point_stall is high the head
// result holds; samples keep coming until fewer than two queue entries are free.
`timescale 1ns / 1ps

module slope_corridor_line_simplifier_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          sample_valid,
	output logic          sample_stall,
	input  scl_pkg::in_t  sample,
	output logic          point_valid,
	input  logic          point_stall,
	output scl_pkg::out_t point,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [15:0]   cfg_data
);

	logic           valid_s1;
	scl_pkg::in_t   item_s1;
	logic [15:0]    capacity_q;
	logic [9:0]     tolerance_q;
	logic           room;
	logic           go;
	logic           accept;
	scl_pkg::emit_t emit;

	assign go           = valid_s1 && room;
	assign sample_stall = valid_s1 && !room;
	assign accept       = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q  <= scl_pkg::CAPACITY_RESET;
			tolerance_q <= scl_pkg::SIMPL_ERR_Q15;
		end else if (cfg_we) begin
			case (cfg_index)
				scl_pkg::REG_CAPACITY:  capacity_q  <= cfg_data;
				scl_pkg::REG_TOLERANCE: tolerance_q <= cfg_data[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= sample;
		end
	end

	scl_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (go),
		.item      (item_s1),
		.capacity  (capacity_q),
		.tolerance (tolerance_q),
		.emit      (emit)
	);

	scl_queue u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.emit        (emit),
		.room        (room),
		.point_valid (point_valid),
		.point_stall (point_stall),
		.point       (point)
	);

endmodule

/* sv/scl_check.sv */
// scl_check: port-level checks on the point channel of the simplifier
// depends on scl_pkg; bound to slope_corridor_line_simplifier_top
`timescale 1ns / 1ps

module scl_check (
	input logic          clk,
	input logic          arst_n,
	input logic          sample_stall,
	input logic          point_valid,
	input logic          point_stall,
	input scl_pkg::out_t point
);

	// a stalled beat stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && point_stall |=> point_valid && $stable(point))
		else $error("point beat changed under stall");

	// error results close the stream
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && (point.status != scl_pkg::ST_OK) |-> point.last_result)
		else $error("error result without last_result");

	// error results carry no point
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		point_valid && (point.status != scl_pkg::ST_OK) |->
		(point.point_tick == 16'd0) && (point.point_value == 16'sd0))
		else $error("error result carries a point");

	// no result can come out of an empty block right after reset
	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |=> !point_valid)
		else $error("result after reset without a sample");

	// input stalls only while a sample is held, so never before the first beat
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !sample_stall)
		else $error("stall raised right after reset");

endmodule

bind slope_corridor_line_simplifier_top scl_check u_check (.*);
